>>> design/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  localparam int CoordW    = 32;
  localparam int DiffW     = 33;
  localparam int ProdW     = 66;
  localparam int DotW      = 68;
  localparam int DivW      = 67;
  localparam int QuotW     = 33;
  localparam int SqW       = 70;
  localparam int RootW     = 34;
  localparam int DistW     = 33;
  localparam int RegionW   = 2;
  localparam int DivCells  = 33;
  localparam int SqrtCells = 34;

  typedef enum logic [RegionW-1:0] {
    REG_DEGEN    = 2'd0,
    REG_START    = 2'd1,
    REG_END      = 2'd2,
    REG_INTERIOR = 2'd3
  } region_t;

  typedef struct packed {
    region_t                  region;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } geo_t;

endpackage

`default_nettype wire

>>> design/psd_pts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psd_pts_if;
  logic                                valid;
  logic                                ready;
  logic signed [psd_pkg::CoordW-1:0]   start_x;
  logic signed [psd_pkg::CoordW-1:0]   start_y;
  logic signed [psd_pkg::CoordW-1:0]   end_x;
  logic signed [psd_pkg::CoordW-1:0]   end_y;
  logic signed [psd_pkg::CoordW-1:0]   check_x;
  logic signed [psd_pkg::CoordW-1:0]   check_y;

  modport source (output valid, start_x, start_y, end_x, end_y, check_x, check_y,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, check_x, check_y,
                output ready);
endinterface

`default_nettype wire

>>> design/psd_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psd_res_if;
  logic                          valid;
  logic                          ready;
  logic [psd_pkg::DistW-1:0]     distance;
  logic [psd_pkg::RegionW-1:0]   region;

  modport source (output valid, distance, region, input ready);
  modport sink (input valid, distance, region, output ready);
endinterface

`default_nettype wire

>>> design/psd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_div_cell #(
  parameter bit SHIFT = 1'b1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [psd_pkg::DivW-1:0]     r_i,
  input  wire logic [psd_pkg::DivW-1:0]     d_i,
  input  wire logic [psd_pkg::QuotW-1:0]    q_i,
  input  wire psd_pkg::geo_t                geo_i,
  output logic                              vld_o,
  output logic [psd_pkg::DivW-1:0]          r_o,
  output logic [psd_pkg::DivW-1:0]          d_o,
  output logic [psd_pkg::QuotW-1:0]         q_o,
  output psd_pkg::geo_t                     geo_o
);

  logic [psd_pkg::DivW-1:0] rs;
  logic                     ge;

  assign rs = SHIFT ? {r_i[psd_pkg::DivW-2:0], 1'b0} : r_i;
  assign ge = rs >= d_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      r_o   <= ge ? rs - d_i : rs;
      d_o   <= d_i;
      q_o   <= {q_i[psd_pkg::QuotW-2:0], ge};
      geo_o <= geo_i;
    end
  end

endmodule

`default_nettype wire

>>> design/psd_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt_cell #(
  parameter int B = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [psd_pkg::SqW-1:0]      rem_i,
  input  wire logic [psd_pkg::RootW-1:0]    root_i,
  input  wire psd_pkg::region_t             region_i,
  output logic                              vld_o,
  output logic [psd_pkg::SqW-1:0]           rem_o,
  output logic [psd_pkg::RootW-1:0]         root_o,
  output psd_pkg::region_t                  region_o
);

  logic [psd_pkg::SqW-1:0] trial;
  logic                    ge;

  assign trial = (psd_pkg::SqW'(root_i) << (B + 1)) + (psd_pkg::SqW'(1) << (2 * B));
  assign ge    = rem_i >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      rem_o    <= ge ? rem_i - trial : rem_i;
      root_o   <= ge ? (root_i | (psd_pkg::RootW'(1) << B)) : root_i;
      region_o <= region_i;
    end
  end

endmodule

`default_nettype wire

>>> design/point_segment_distance_2d.sv
// channel | dir | payload                                      | handshake
// pts     | in  | start_x start_y end_x end_y check_x check_y  | valid/ready
// res     | out | distance region                              | valid/ready
//
// one request accepted per cycle while no result waits on res.ready, one result per request
// path: 3 front stages, 33 quotient cells, 5 projection/square stages,
// 34 root cells and the output register
// rst clears every valid bit; payload registers are not reset
// the whole pipeline holds while a result waits on res.ready
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_2d (
  input wire logic  clk,
  input wire logic  rst,
  psd_pts_if.sink   pts,
  psd_res_if.source res
);

  localparam int CW = psd_pkg::CoordW;
  localparam int DW = psd_pkg::DiffW;
  localparam int ND = psd_pkg::DivCells;
  localparam int NS = psd_pkg::SqrtCells;

  logic en;
  assign en        = !res.valid || res.ready;
  assign pts.ready = en;

  // stage a: differences
  logic                 a_vld;
  logic signed [CW-1:0] a_sx, a_sy, a_ex, a_ey, a_cx, a_cy;
  logic signed [DW-1:0] a_dx, a_dy, a_px, a_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= pts.valid;
    end
    if (en) begin
      a_sx <= pts.start_x;
      a_sy <= pts.start_y;
      a_ex <= pts.end_x;
      a_ey <= pts.end_y;
      a_cx <= pts.check_x;
      a_cy <= pts.check_y;
      a_dx <= DW'(pts.end_x) - DW'(pts.start_x);
      a_dy <= DW'(pts.end_y) - DW'(pts.start_y);
      a_px <= DW'(pts.check_x) - DW'(pts.start_x);
      a_py <= DW'(pts.check_y) - DW'(pts.start_y);
    end
  end

  // stage b: products
  logic                                b_vld, b_degen;
  logic signed [CW-1:0]                b_sx, b_sy, b_ex, b_ey, b_cx, b_cy;
  logic signed [DW-1:0]                b_dx, b_dy;
  logic signed [psd_pkg::ProdW-1:0]    b_dxx, b_dyy, b_pxd, b_pyd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_sx    <= a_sx;
      b_sy    <= a_sy;
      b_ex    <= a_ex;
      b_ey    <= a_ey;
      b_cx    <= a_cx;
      b_cy    <= a_cy;
      b_dx    <= a_dx;
      b_dy    <= a_dy;
      b_degen <= (a_dx == '0) && (a_dy == '0);
      b_dxx   <= a_dx * a_dx;
      b_dyy   <= a_dy * a_dy;
      b_pxd   <= a_px * a_dx;
      b_pyd   <= a_py * a_dy;
    end
  end

  // stage c: squared length and dot product
  logic                              c_vld, c_degen;
  logic signed [CW-1:0]              c_sx, c_sy, c_ex, c_ey, c_cx, c_cy;
  logic signed [DW-1:0]              c_dx, c_dy;
  logic [psd_pkg::DivW-1:0]          c_l2;
  logic signed [psd_pkg::DotW-1:0]   c_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
    if (en) begin
      c_sx    <= b_sx;
      c_sy    <= b_sy;
      c_ex    <= b_ex;
      c_ey    <= b_ey;
      c_cx    <= b_cx;
      c_cy    <= b_cy;
      c_dx    <= b_dx;
      c_dy    <= b_dy;
      c_degen <= b_degen;
      c_l2    <= psd_pkg::DivW'($unsigned(b_dxx)) + psd_pkg::DivW'($unsigned(b_dyy));
      c_dot   <= psd_pkg::DotW'(b_pxd) + psd_pkg::DotW'(b_pyd);
    end
  end

  psd_pkg::region_t c_region;
  psd_pkg::geo_t    c_geo;

  always_comb begin
    priority if (c_degen) begin
      c_region = psd_pkg::REG_DEGEN;
    end else if (c_dot < 0) begin
      c_region = psd_pkg::REG_START;
    end else if ($unsigned(c_dot) > {1'b0, c_l2}) begin
      c_region = psd_pkg::REG_END;
    end else begin
      c_region = psd_pkg::REG_INTERIOR;
    end
    c_geo.region = c_region;
    c_geo.dx     = c_dx;
    c_geo.dy     = c_dy;
    c_geo.sx     = c_sx;
    c_geo.sy     = c_sy;
    c_geo.qx     = (c_region == psd_pkg::REG_END) ? c_ex : c_sx;
    c_geo.qy     = (c_region == psd_pkg::REG_END) ? c_ey : c_sy;
    c_geo.cx     = c_cx;
    c_geo.cy     = c_cy;
  end

  // quotient chain
  logic                         vld_d [0:ND];
  logic [psd_pkg::DivW-1:0]     r_d   [0:ND];
  logic [psd_pkg::DivW-1:0]     l2_d  [0:ND];
  logic [psd_pkg::QuotW-1:0]    q_d   [0:ND];
  psd_pkg::geo_t                geo_d [0:ND];

  assign vld_d[0] = c_vld;
  assign r_d[0]   = c_dot[psd_pkg::DivW-1:0];
  assign l2_d[0]  = c_l2;
  assign q_d[0]   = '0;
  assign geo_d[0] = c_geo;

  for (genvar k = 0; k < ND; k++) begin : g_div
    psd_div_cell #(.SHIFT(k != 0)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_i (vld_d[k]),
      .r_i   (r_d[k]),
      .d_i   (l2_d[k]),
      .q_i   (q_d[k]),
      .geo_i (geo_d[k]),
      .vld_o (vld_d[k+1]),
      .r_o   (r_d[k+1]),
      .d_o   (l2_d[k+1]),
      .q_o   (q_d[k+1]),
      .geo_o (geo_d[k+1])
    );
  end

  // stage e: offset along the segment
  logic [DW-1:0]  mag_dx, mag_dy;
  logic           e_vld;
  psd_pkg::geo_t  e_geo;
  logic [64:0]    e_mx, e_my;

  assign mag_dx = geo_d[ND].dx[DW-1] ? DW'(-geo_d[ND].dx) : DW'(geo_d[ND].dx);
  assign mag_dy = geo_d[ND].dy[DW-1] ? DW'(-geo_d[ND].dy) : DW'(geo_d[ND].dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= vld_d[ND];
    end
    if (en) begin
      e_geo <= geo_d[ND];
      e_mx  <= 65'(mag_dx[CW-1:0]) * 65'(q_d[ND]);
      e_my  <= 65'(mag_dy[CW-1:0]) * 65'(q_d[ND]);
    end
  end

  // stage f: projected point
  logic [65:0]     rnd_x, rnd_y;
  logic signed [34:0] pj_x, pj_y;
  logic               f_vld;
  psd_pkg::region_t   f_region;
  logic signed [CW-1:0] f_px, f_py, f_cx, f_cy;

  assign rnd_x = 66'(e_mx) + 66'(32'hFFFF_FFFF);
  assign rnd_y = 66'(e_my) + 66'(32'hFFFF_FFFF);
  assign pj_x  = e_geo.dx[DW-1] ? 35'(e_geo.sx) - $signed({1'b0, rnd_x[65:32]})
                                : 35'(e_geo.sx) + $signed({2'b0, e_mx[64:32]});
  assign pj_y  = e_geo.dy[DW-1] ? 35'(e_geo.sy) - $signed({1'b0, rnd_y[65:32]})
                                : 35'(e_geo.sy) + $signed({2'b0, e_my[64:32]});

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
    if (en) begin
      f_region <= e_geo.region;
      f_px     <= (e_geo.region == psd_pkg::REG_INTERIOR) ? pj_x[CW-1:0] : e_geo.qx;
      f_py     <= (e_geo.region == psd_pkg::REG_INTERIOR) ? pj_y[CW-1:0] : e_geo.qy;
      f_cx     <= e_geo.cx;
      f_cy     <= e_geo.cy;
    end
  end

  // stage g: magnitudes of the offset to the check point
  logic signed [DW-1:0] g_ddx, g_ddy;
  logic                 g_vld;
  psd_pkg::region_t     g_region;
  logic [CW-1:0]        g_mx, g_my;

  assign g_ddx = DW'(f_px) - DW'(f_cx);
  assign g_ddy = DW'(f_py) - DW'(f_cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
    if (en) begin
      g_region <= f_region;
      g_mx     <= g_ddx[DW-1] ? CW'(-g_ddx) : CW'(g_ddx);
      g_my     <= g_ddy[DW-1] ? CW'(-g_ddy) : CW'(g_ddy);
    end
  end

  // stage h: squares, stage i: sum
  logic             h_vld, i_vld;
  psd_pkg::region_t h_region, i_region;
  logic [63:0]      h_sx, h_sy;
  logic [64:0]      i_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
      i_vld <= 1'b0;
    end else if (en) begin
      h_vld <= g_vld;
      i_vld <= h_vld;
    end
    if (en) begin
      h_region <= g_region;
      h_sx     <= 64'(g_mx) * 64'(g_mx);
      h_sy     <= 64'(g_my) * 64'(g_my);
      i_region <= h_region;
      i_sum    <= 65'(h_sx) + 65'(h_sy);
    end
  end

  // root chain
  logic                       vld_s  [0:NS];
  logic [psd_pkg::SqW-1:0]    rem_s  [0:NS];
  logic [psd_pkg::RootW-1:0]  root_s [0:NS];
  psd_pkg::region_t           reg_s  [0:NS];

  assign vld_s[0]  = i_vld;
  assign rem_s[0]  = psd_pkg::SqW'(i_sum);
  assign root_s[0] = '0;
  assign reg_s[0]  = i_region;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    psd_sqrt_cell #(.B(NS - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_i    (vld_s[k]),
      .rem_i    (rem_s[k]),
      .root_i   (root_s[k]),
      .region_i (reg_s[k]),
      .vld_o    (vld_s[k+1]),
      .rem_o    (rem_s[k+1]),
      .root_o   (root_s[k+1]),
      .region_o (reg_s[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= vld_s[NS];
    end
    if (en) begin
      res.distance <= root_s[NS][psd_pkg::DistW-1:0];
      res.region   <= reg_s[NS];
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (vld_d[ND] && geo_d[ND].region == psd_pkg::REG_INTERIOR)
      |-> (!q_d[ND][psd_pkg::QuotW-1] || q_d[ND][psd_pkg::QuotW-2:0] == '0))
    else $error("projection fraction above one");

  a_stall_holds: assert property (@(posedge clk) (!en && !rst)
    |=> ($stable(a_vld) && $stable(vld_d[ND]) && $stable(vld_s[NS])))
    else $error("pipeline moved during stall");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    vld_s[NS] |-> !root_s[NS][psd_pkg::RootW-1])
    else $error("root exceeds distance width");

endmodule

`default_nettype wire
